[rtl/abst_pkg.sv]
// Package for the array-embedded binary search tree unit.
// Holds default parameters, operation and status codes, and the sequencer states.
// No dependencies.
`default_nettype none

package abst_pkg;

    // Default tree depth and key width
    localparam int LEVELS_DEF   = 7;
    localparam int KEY_BITS_DEF = 16;

    // Fixed port widths
    localparam int OP_W     = 2;
    localparam int KEY_IN_W = 16;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_NO_ROOM   = 3'd3,
        ST_ZERO_KEY  = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_RM_L,
        S_RM_LCHK,
        S_RM_RCHK,
        S_RM_DESC,
        S_RM_MOVE,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[rtl/array_binary_search_tree_unit.sv]
// Top level of the array-embedded binary search tree unit.
// Holds the node store memory and the walk/delete sequencer; depends on abst_pkg.
`default_nettype none

// The unit keeps a binary search tree in a node store of 2^LEVELS keys, the
// root at slot 1 and the children of slot i at 2i and 2i+1; a key of zero
// marks an empty slot. Each input beat is one request (insert, find or
// delete) and yields exactly one result beat with a status and a slot
// index. After reset the unit sweeps the store to zero, one slot per cycle,
// so o_in_ready stays low until every slot has been cleared.
// Requests are served one at a time and o_in_ready is high only while the
// sequencer is idle. Walking is paced by the registered store read, whose
// data for each visited node decides the next address. Insert and find walk
// down the tree, then post the result through the done state into the
// output register, and o_in_ready returns high in the same cycle as
// o_out_valid. Delete goes on from the matched node with replacement steps:
// it probes the left child and, when that is empty, the right child,
// follows the predecessor or successor chain below the chosen child, moves
// the replacement key up and repeats at its old slot; it ends by emptying the
// final leaf. A finished result is held in an output register, so the next
// request is taken while that result still waits for i_out_ready.
module array_binary_search_tree_unit #(
    parameter int LEVELS   = abst_pkg::LEVELS_DEF,
    parameter int KEY_BITS = abst_pkg::KEY_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [abst_pkg::OP_W-1:0]     i_op,
    input  wire logic [abst_pkg::KEY_IN_W-1:0] i_key,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [abst_pkg::STATUS_W-1:0]      o_status,
    output logic [abst_pkg::SLOT_W-1:0]        o_slot_index
);

    localparam int DEPTH = 1 << LEVELS;
    localparam int IW    = (KEY_BITS > abst_pkg::KEY_IN_W) ? KEY_BITS : abst_pkg::KEY_IN_W;
    localparam int SW    = (LEVELS > abst_pkg::SLOT_W) ? LEVELS : abst_pkg::SLOT_W;

    // Child slot of s in direction d (0 left, 1 right); caller checks s is not bottom
    function automatic logic [LEVELS-1:0] child(input logic [LEVELS-1:0] s, input logic d);
        child = {s[LEVELS-2:0], d};
    endfunction

    // Node store
    logic [KEY_BITS-1:0] r_mem [DEPTH];
    logic [KEY_BITS-1:0] r_rdata;

    logic                rd_en;
    logic [LEVELS-1:0]   rd_addr;
    logic                wr_en;
    logic [LEVELS-1:0]   wr_addr;
    logic [KEY_BITS-1:0] wr_data;

    // Sequencer state
    abst_pkg::t_state    r_state, n_state;
    logic [LEVELS-1:0]   r_cur, n_cur;
    logic [LEVELS-1:0]   r_pick, n_pick;
    logic [LEVELS-1:0]   r_next, n_next;
    logic [KEY_BITS-1:0] r_pick_key, n_pick_key;
    logic                r_dir, n_dir;
    logic [abst_pkg::OP_W-1:0] r_op, n_op;
    logic [KEY_BITS-1:0] r_key, n_key;
    abst_pkg::t_status   r_res_status, n_res_status;
    logic [LEVELS-1:0]   r_res_slot, n_res_slot;

    // Output register
    logic                r_out_valid, n_out_valid;
    abst_pkg::t_status   r_status, n_status;
    logic [abst_pkg::SLOT_W-1:0] r_slot, n_slot;

    // Key taken modulo 2^KEY_BITS
    logic [IW-1:0]       in_key_ext;
    logic [KEY_BITS-1:0] in_key;
    assign in_key_ext = IW'(i_key);
    assign in_key     = in_key_ext[KEY_BITS-1:0];

    logic [SW-1:0] res_slot_ext;
    assign res_slot_ext = SW'(r_res_slot);

    // Shared compare unit and slot helpers
    logic              key_lt;
    logic              cur_bottom;
    logic [LEVELS-1:0] left_slot;
    logic [LEVELS-1:0] right_slot;
    assign key_lt     = r_key < r_rdata;
    assign cur_bottom = r_cur[LEVELS-1];
    assign left_slot  = child(r_cur, 1'b0);
    assign right_slot = child(r_cur, 1'b1);

    assign o_in_ready   = (r_state == abst_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_slot_index = r_slot;

    // Memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= abst_pkg::S_CLEAR;
            r_cur       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pick       <= n_pick;
        r_next       <= n_next;
        r_pick_key   <= n_pick_key;
        r_dir        <= n_dir;
        r_op         <= n_op;
        r_key        <= n_key;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_status     <= n_status;
        r_slot       <= n_slot;
    end

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_pick       = r_pick;
        n_next       = r_next;
        n_pick_key   = r_pick_key;
        n_dir        = r_dir;
        n_op         = r_op;
        n_key        = r_key;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_status     = r_status;
        n_slot       = r_slot;
        n_out_valid  = r_out_valid;
        rd_en        = 1'b0;
        rd_addr      = r_cur;
        wr_en        = 1'b0;
        wr_addr      = r_cur;
        wr_data      = '0;

        // Drop the held result once it is taken
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            abst_pkg::S_CLEAR: begin
                // Sweep the store to empty after reset
                wr_en = 1'b1;
                if (&r_cur) begin
                    n_state = abst_pkg::S_IDLE;
                end
                n_cur = r_cur + LEVELS'(1);
            end

            abst_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op       = i_op;
                    n_key      = in_key;
                    n_cur      = LEVELS'(1);
                    n_res_slot = '0;
                    if (in_key == '0) begin
                        n_res_status = abst_pkg::ST_ZERO_KEY;
                        n_state      = abst_pkg::S_DONE;
                    end else if (i_op != abst_pkg::OP_INSERT && i_op != abst_pkg::OP_FIND
                                 && i_op != abst_pkg::OP_DELETE) begin
                        n_res_status = abst_pkg::ST_NOT_FOUND;
                        n_state      = abst_pkg::S_DONE;
                    end else begin
                        // Fetch the root
                        rd_en   = 1'b1;
                        rd_addr = LEVELS'(1);
                        n_state = abst_pkg::S_WALK;
                    end
                end
            end

            abst_pkg::S_WALK: begin
                // r_rdata holds the key at r_cur
                if (r_rdata == '0) begin
                    n_state = abst_pkg::S_DONE;
                    if (r_op == abst_pkg::OP_INSERT) begin
                        wr_en        = 1'b1;
                        wr_data      = r_key;
                        n_res_status = abst_pkg::ST_OK;
                        n_res_slot   = r_cur;
                    end else begin
                        n_res_status = abst_pkg::ST_NOT_FOUND;
                    end
                end else if (r_rdata == r_key) begin
                    if (r_op == abst_pkg::OP_INSERT) begin
                        n_res_status = abst_pkg::ST_DUPLICATE;
                        n_state      = abst_pkg::S_DONE;
                    end else begin
                        n_res_status = abst_pkg::ST_OK;
                        n_res_slot   = r_cur;
                        n_state      = (r_op == abst_pkg::OP_DELETE) ?
                                       abst_pkg::S_RM_L : abst_pkg::S_DONE;
                    end
                end else if (cur_bottom) begin
                    // Path runs past the last slot
                    n_res_status = (r_op == abst_pkg::OP_INSERT) ?
                                   abst_pkg::ST_NO_ROOM : abst_pkg::ST_NOT_FOUND;
                    n_state      = abst_pkg::S_DONE;
                end else begin
                    // Advance one level
                    n_cur   = child(r_cur, ~key_lt);
                    rd_en   = 1'b1;
                    rd_addr = child(r_cur, ~key_lt);
                end
            end

            abst_pkg::S_RM_L: begin
                if (cur_bottom) begin
                    // No children inside the store: empty this leaf
                    wr_en   = 1'b1;
                    n_state = abst_pkg::S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = left_slot;
                    n_state = abst_pkg::S_RM_LCHK;
                end
            end

            abst_pkg::S_RM_LCHK: begin
                if (r_rdata != '0) begin
                    // Predecessor: rightmost node of the left subtree
                    n_pick     = left_slot;
                    n_pick_key = r_rdata;
                    n_dir      = 1'b1;
                    if (left_slot[LEVELS-1]) begin
                        n_state = abst_pkg::S_RM_MOVE;
                    end else begin
                        n_next  = child(left_slot, 1'b1);
                        rd_en   = 1'b1;
                        rd_addr = child(left_slot, 1'b1);
                        n_state = abst_pkg::S_RM_DESC;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = right_slot;
                    n_state = abst_pkg::S_RM_RCHK;
                end
            end

            abst_pkg::S_RM_RCHK: begin
                if (r_rdata != '0) begin
                    // Successor: leftmost node of the right subtree
                    n_pick     = right_slot;
                    n_pick_key = r_rdata;
                    n_dir      = 1'b0;
                    if (right_slot[LEVELS-1]) begin
                        n_state = abst_pkg::S_RM_MOVE;
                    end else begin
                        n_next  = child(right_slot, 1'b0);
                        rd_en   = 1'b1;
                        rd_addr = child(right_slot, 1'b0);
                        n_state = abst_pkg::S_RM_DESC;
                    end
                end else begin
                    // Both children empty: clear the node
                    wr_en   = 1'b1;
                    n_state = abst_pkg::S_DONE;
                end
            end

            abst_pkg::S_RM_DESC: begin
                // r_rdata holds the key at r_next
                if (r_rdata != '0) begin
                    n_pick     = r_next;
                    n_pick_key = r_rdata;
                    if (r_next[LEVELS-1]) begin
                        n_state = abst_pkg::S_RM_MOVE;
                    end else begin
                        n_next  = child(r_next, r_dir);
                        rd_en   = 1'b1;
                        rd_addr = child(r_next, r_dir);
                    end
                end else begin
                    n_state = abst_pkg::S_RM_MOVE;
                end
            end

            abst_pkg::S_RM_MOVE: begin
                // Pull the replacement key up and continue at its old slot
                wr_en   = 1'b1;
                wr_data = r_pick_key;
                n_cur   = r_pick;
                n_state = abst_pkg::S_RM_L;
            end

            abst_pkg::S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_status;
                    n_slot      = res_slot_ext[abst_pkg::SLOT_W-1:0];
                    n_state     = abst_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = abst_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
